### hw/rtl/rcwcs_pkg.sv
`default_nettype none

package rcwcs_pkg;

    // Field widths
    localparam int COL_W   = 8;
    localparam int COORD_W = 16;
    localparam int W_W     = 12;   // screen width / height registers
    localparam int CFG_W   = 12;

    // Angle arithmetic, 2^ANG_W steps per turn
    localparam int ANG_W   = 12;
    localparam int A_W     = ANG_W - 1;          // folded angle 0 .. quarter turn
    localparam int ASQ_W   = 2 * ANG_W - 3;      // a^2
    localparam int DEN_W   = 2 * ANG_W + 1;      // 2^(2A) + 4a^2
    localparam logic [ANG_W-1:0] ANG_HALF = ANG_W'(1 << (ANG_W - 1));
    localparam logic [ANG_W-1:0] ANG_QTR  = ANG_W'(1 << (ANG_W - 2));
    localparam logic [DEN_W-1:0] COS_ONE  = DEN_W'(1) << (2 * ANG_W);

    // Cosine result, Q1.14
    localparam int COS_FRAC  = 14;
    localparam int COS_W     = COS_FRAC + 1;
    localparam int COS_STEPS = COS_W;

    // Shading
    localparam int W16_W      = W_W + 4;          // 16 * width
    localparam int DIFF_W     = W16_W + 8;        // 16 * width * 255 and 150 * depth
    localparam int HN_W       = W_W + 10;         // height * 800
    localparam int BLUE_W     = 8;
    localparam int BLUE_STEPS = BLUE_W;
    localparam int BAR_W      = 12;
    localparam int BAR_STEPS  = BAR_W;

    localparam logic [7:0] BLUE_BRIGHT = 8'd255;   // 150 + 105
    localparam logic [7:0] BLUE_DIM    = 8'd140;   // 150 - 10
    localparam logic [7:0] BLUE_FALL   = 8'd150;
    localparam logic [9:0] BAR_SCALE   = 10'd800;  // 50 * 16 for Q12.4 distance
    localparam logic [BLUE_W-1:0] BLUE_MAX = 8'd255;

    typedef enum logic [1:0] {
        REG_FISHEYE = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [COL_W-1:0]   col;
        logic               hit;
        logic [COORD_W-1:0] depth;
        logic               bright;
    } item_t;

endpackage

`default_nettype wire

### hw/rtl/rcwcs_fisheye.sv
`default_nettype none

module rcwcs_fisheye import rcwcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic               fisheye_correct,
    input  wire logic               in_vld,
    input  wire item_t              in_item,
    input  wire logic [ANG_W-1:0]   view_angle,
    input  wire logic [ANG_W-1:0]   ray_angle,
    input  wire logic [COORD_W-1:0] origin_x,
    input  wire logic [COORD_W-1:0] origin_y,
    input  wire logic [COORD_W-1:0] wall_start_x,
    input  wire logic [COORD_W-1:0] wall_start_y,
    input  wire logic [COORD_W-1:0] wall_end_x,
    input  wire logic [COORD_W-1:0] wall_end_y,
    output logic                    out_vld,
    output item_t                   out_item
);

    // stage A: angle fold, wall side test
    logic             a_vld_reg;
    item_t            a_item_reg;
    logic [A_W-1:0]   a_ang_reg;
    logic             a_neg_reg;
    // stage B: a^2
    logic             b_vld_reg;
    item_t            b_item_reg;
    logic             b_neg_reg;
    logic [ASQ_W-1:0] b_asq_reg;
    // stage C: numerator / denominator of the rational cosine
    logic             c_vld_reg;
    item_t            c_item_reg;
    logic             c_neg_reg;
    logic [DEN_W-1:0] c_num_reg;
    logic [DEN_W-1:0] c_den_reg;
    // divider stages, one quotient bit each
    logic             dv_vld_reg  [COS_STEPS];
    item_t            dv_item_reg [COS_STEPS];
    logic             dv_neg_reg  [COS_STEPS];
    logic [DEN_W-1:0] dv_rem_reg  [COS_STEPS];
    logic [DEN_W-1:0] dv_den_reg  [COS_STEPS];
    logic [COS_W-1:0] dv_q_reg    [COS_STEPS];
    logic [DEN_W-1:0] dv_rem_next [COS_STEPS];
    logic [COS_W-1:0] dv_q_next   [COS_STEPS];
    // stage M: distance times cosine
    logic             m_vld_reg;
    item_t            m_item_reg;

    logic [ANG_W-1:0]         ang_diff;
    logic [ANG_W-1:0]         ang_fold;
    logic                     a_neg_next;
    logic [A_W-1:0]           a_ang_next;
    logic                     bright_next;
    item_t                    a_item_next;
    logic [2*A_W-1:0]         asq_full;
    item_t                    m_item_next;
    logic [COORD_W+COS_W-1:0] dist_prod;

    always_comb
    begin
        ang_diff   = view_angle - ray_angle;
        ang_fold   = (ang_diff > ANG_HALF) ? (ANG_W'(0) - ang_diff) : ang_diff;
        a_neg_next = ang_fold > ANG_QTR;
        a_ang_next = a_neg_next ? A_W'(ANG_HALF - ang_fold) : A_W'(ang_fold);
        // origin above a horizontal wall or right of a vertical wall
        bright_next = ((wall_start_y == wall_end_y) && (origin_y < wall_start_y)) ||
                      ((wall_start_x == wall_end_x) && (origin_x > wall_start_x));
        a_item_next        = in_item;
        a_item_next.bright = bright_next;
    end

    assign asq_full = a_ang_reg * a_ang_reg;

    // restoring division, quotient below 2^COS_W so the first remainder is num >> 1
    always_comb
    begin
        logic [DEN_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [COS_W-1:0] q_in;
        logic             bit_in;
        logic [DEN_W:0]   trial;
        for (int k = 0; k < COS_STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in = c_num_reg >> 1;
                bit_in = c_num_reg[0];
                den_in = c_den_reg;
                q_in   = '0;
            end
            else
            begin
                rem_in = dv_rem_reg[k-1];
                bit_in = 1'b0;
                den_in = dv_den_reg[k-1];
                q_in   = dv_q_reg[k-1];
            end
            trial = {rem_in, bit_in};
            if (trial >= {1'b0, den_in})
            begin
                dv_rem_next[k] = DEN_W'(trial - {1'b0, den_in});
                dv_q_next[k]   = {q_in[COS_W-2:0], 1'b1};
            end
            else
            begin
                dv_rem_next[k] = trial[DEN_W-1:0];
                dv_q_next[k]   = {q_in[COS_W-2:0], 1'b0};
            end
        end
    end

    assign dist_prod = dv_item_reg[COS_STEPS-1].depth * dv_q_reg[COS_STEPS-1];

    always_comb
    begin
        m_item_next = dv_item_reg[COS_STEPS-1];
        if (fisheye_correct)
        begin
            m_item_next.depth = dv_neg_reg[COS_STEPS-1] ? '0
                                                        : dist_prod[COS_FRAC +: COORD_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            m_vld_reg <= 1'b0;
            for (int k = 0; k < COS_STEPS; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            a_vld_reg     <= in_vld;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            dv_vld_reg[0] <= c_vld_reg;
            for (int k = 1; k < COS_STEPS; k++)
            begin
                dv_vld_reg[k] <= dv_vld_reg[k-1];
            end
            m_vld_reg <= dv_vld_reg[COS_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_item_reg <= a_item_next;
            a_ang_reg  <= a_ang_next;
            a_neg_reg  <= a_neg_next;

            b_item_reg <= a_item_reg;
            b_neg_reg  <= a_neg_reg;
            b_asq_reg  <= asq_full[ASQ_W-1:0];

            c_item_reg <= b_item_reg;
            c_neg_reg  <= b_neg_reg;
            c_num_reg  <= COS_ONE - {b_asq_reg, 4'b0000};
            c_den_reg  <= COS_ONE + DEN_W'({b_asq_reg, 2'b00});

            for (int k = 0; k < COS_STEPS; k++)
            begin
                dv_item_reg[k] <= (k == 0) ? c_item_reg : dv_item_reg[k-1];
                dv_neg_reg[k]  <= (k == 0) ? c_neg_reg  : dv_neg_reg[k-1];
                dv_den_reg[k]  <= (k == 0) ? c_den_reg  : dv_den_reg[k-1];
                dv_rem_reg[k]  <= dv_rem_next[k];
                dv_q_reg[k]    <= dv_q_next[k];
            end

            m_item_reg <= m_item_next;
        end
    end

    assign out_vld  = m_vld_reg;
    assign out_item = m_item_reg;

endmodule

`default_nettype wire

### hw/rtl/rcwcs_shade.sv
`default_nettype none

module rcwcs_shade import rcwcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               adv,
    input  wire logic [W_W-1:0]     screen_width,
    input  wire logic [W_W-1:0]     screen_height,
    input  wire logic               in_vld,
    input  wire item_t              in_item,
    output logic                    out_vld,
    output logic [COL_W-1:0]        out_column,
    output logic                    draw,
    output logic [BLUE_W-1:0]       blue_level,
    output logic [BAR_W-1:0]        bar_height
);

    // stage P: constant products
    logic               p_vld_reg;
    item_t              p_item_reg;
    logic [DIFF_W-1:0]  p_pos_reg;
    logic [DIFF_W-1:0]  p_negp_reg;
    logic [HN_W-1:0]    p_hn_reg;
    logic [W16_W-1:0]   p_w16_reg;
    // stage Q: brightness numerator
    logic               q_vld_reg;
    item_t              q_item_reg;
    logic               q_pos_reg;
    logic [DIFF_W-1:0]  q_diff_reg;
    logic [HN_W-1:0]    q_hn_reg;
    logic [W16_W-1:0]   q_w16_reg;
    // stage R: saturation tests, first remainders
    logic               r_vld_reg;
    item_t              r_item_reg;
    logic               r_bzero_reg;
    logic               r_bsat_reg;
    logic [W16_W-1:0]   r_brem_reg;
    logic [BLUE_W-1:0]  r_blo_reg;
    logic [W16_W-1:0]   r_w16_reg;
    logic               r_hsat_reg;
    logic [COORD_W-1:0] r_hrem_reg;
    logic [BAR_W-1:0]   r_hlo_reg;
    // divider stages: bar on every stage, blue on the first BLUE_STEPS
    logic               s_vld_reg   [BAR_STEPS];
    item_t              s_item_reg  [BAR_STEPS];
    logic               s_bzero_reg [BAR_STEPS];
    logic               s_bsat_reg  [BAR_STEPS];
    logic [W16_W-1:0]   s_brem_reg  [BAR_STEPS];
    logic [BLUE_W-1:0]  s_blo_reg   [BAR_STEPS];
    logic [BLUE_W-1:0]  s_bq_reg    [BAR_STEPS];
    logic [W16_W-1:0]   s_w16_reg   [BAR_STEPS];
    logic               s_hsat_reg  [BAR_STEPS];
    logic [COORD_W-1:0] s_hrem_reg  [BAR_STEPS];
    logic [BAR_W-1:0]   s_hlo_reg   [BAR_STEPS];
    logic [BAR_W-1:0]   s_hq_reg    [BAR_STEPS];

    logic [W16_W-1:0]   s_brem_next [BAR_STEPS];
    logic [BLUE_W-1:0]  s_blo_next  [BAR_STEPS];
    logic [BLUE_W-1:0]  s_bq_next   [BAR_STEPS];
    logic [COORD_W-1:0] s_hrem_next [BAR_STEPS];
    logic [BAR_W-1:0]   s_hlo_next  [BAR_STEPS];
    logic [BAR_W-1:0]   s_hq_next   [BAR_STEPS];

    // output stage
    logic               o_vld_reg;
    logic [COL_W-1:0]   o_col_reg;
    logic               o_draw_reg;
    logic [BLUE_W-1:0]  o_blue_reg;
    logic [BAR_W-1:0]   o_bar_reg;

    logic [W_W-1:0]     w_eff;
    logic [7:0]         blue_top;
    logic [BLUE_W-1:0]  blue_next;
    logic [BAR_W-1:0]   bar_next;
    item_t              s_last;

    always_comb
    begin
        w_eff    = (screen_width == '0) ? W_W'(1) : screen_width;
        blue_top = in_item.bright ? BLUE_BRIGHT : BLUE_DIM;
    end

    always_comb
    begin
        logic [W16_W-1:0]   brem_in;
        logic [BLUE_W-1:0]  blo_in;
        logic [BLUE_W-1:0]  bq_in;
        logic [W16_W-1:0]   w16_in;
        logic [COORD_W-1:0] hrem_in;
        logic [BAR_W-1:0]   hlo_in;
        logic [BAR_W-1:0]   hq_in;
        logic [COORD_W-1:0] depth_in;
        logic [W16_W:0]     btrial;
        logic [COORD_W:0]   htrial;
        for (int k = 0; k < BAR_STEPS; k++)
        begin
            if (k == 0)
            begin
                brem_in  = r_brem_reg;
                blo_in   = r_blo_reg;
                bq_in    = '0;
                w16_in   = r_w16_reg;
                hrem_in  = r_hrem_reg;
                hlo_in   = r_hlo_reg;
                hq_in    = '0;
                depth_in = r_item_reg.depth;
            end
            else
            begin
                brem_in  = s_brem_reg[k-1];
                blo_in   = s_blo_reg[k-1];
                bq_in    = s_bq_reg[k-1];
                w16_in   = s_w16_reg[k-1];
                hrem_in  = s_hrem_reg[k-1];
                hlo_in   = s_hlo_reg[k-1];
                hq_in    = s_hq_reg[k-1];
                depth_in = s_item_reg[k-1].depth;
            end

            btrial = {brem_in, blo_in[BLUE_W-1]};
            if (k >= BLUE_STEPS)
            begin
                s_brem_next[k] = brem_in;
                s_blo_next[k]  = blo_in;
                s_bq_next[k]   = bq_in;
            end
            else if (btrial >= {1'b0, w16_in})
            begin
                s_brem_next[k] = W16_W'(btrial - {1'b0, w16_in});
                s_blo_next[k]  = {blo_in[BLUE_W-2:0], 1'b0};
                s_bq_next[k]   = {bq_in[BLUE_W-2:0], 1'b1};
            end
            else
            begin
                s_brem_next[k] = btrial[W16_W-1:0];
                s_blo_next[k]  = {blo_in[BLUE_W-2:0], 1'b0};
                s_bq_next[k]   = {bq_in[BLUE_W-2:0], 1'b0};
            end

            htrial = {hrem_in, hlo_in[BAR_W-1]};
            s_hlo_next[k] = {hlo_in[BAR_W-2:0], 1'b0};
            if (htrial >= {1'b0, depth_in})
            begin
                s_hrem_next[k] = COORD_W'(htrial - {1'b0, depth_in});
                s_hq_next[k]   = {hq_in[BAR_W-2:0], 1'b1};
            end
            else
            begin
                s_hrem_next[k] = htrial[COORD_W-1:0];
                s_hq_next[k]   = {hq_in[BAR_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        s_last = s_item_reg[BAR_STEPS-1];
        if (!s_last.hit || s_bzero_reg[BAR_STEPS-1])
        begin
            blue_next = '0;
        end
        else if (s_bsat_reg[BAR_STEPS-1])
        begin
            blue_next = BLUE_MAX;
        end
        else
        begin
            blue_next = s_bq_reg[BAR_STEPS-1];
        end

        if (!s_last.hit)
        begin
            bar_next = '0;
        end
        else if (s_hsat_reg[BAR_STEPS-1] || (s_hq_reg[BAR_STEPS-1] > screen_height))
        begin
            bar_next = screen_height;
        end
        else
        begin
            bar_next = s_hq_reg[BAR_STEPS-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
            q_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
            o_vld_reg <= 1'b0;
            for (int k = 0; k < BAR_STEPS; k++)
            begin
                s_vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            p_vld_reg    <= in_vld;
            q_vld_reg    <= p_vld_reg;
            r_vld_reg    <= q_vld_reg;
            s_vld_reg[0] <= r_vld_reg;
            for (int k = 1; k < BAR_STEPS; k++)
            begin
                s_vld_reg[k] <= s_vld_reg[k-1];
            end
            o_vld_reg <= s_vld_reg[BAR_STEPS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_item_reg <= in_item;
            p_pos_reg  <= (DIFF_W'(w_eff) * DIFF_W'(blue_top)) << 4;
            p_negp_reg <= DIFF_W'(in_item.depth) * DIFF_W'(BLUE_FALL);
            p_hn_reg   <= HN_W'(screen_height) * HN_W'(BAR_SCALE);
            p_w16_reg  <= {w_eff, 4'b0000};

            q_item_reg <= p_item_reg;
            q_pos_reg  <= p_pos_reg > p_negp_reg;
            q_diff_reg <= p_pos_reg - p_negp_reg;
            q_hn_reg   <= p_hn_reg;
            q_w16_reg  <= p_w16_reg;

            r_item_reg  <= q_item_reg;
            r_bzero_reg <= !q_pos_reg;
            r_bsat_reg  <= q_diff_reg >= {q_w16_reg, BLUE_W'(0)};
            r_brem_reg  <= q_diff_reg[DIFF_W-1 -: W16_W];
            r_blo_reg   <= q_diff_reg[BLUE_W-1:0];
            r_w16_reg   <= q_w16_reg;
            // zero distance or quotient of 2^BAR_W or more: capped at height
            r_hsat_reg  <= (q_item_reg.depth == '0) ||
                           ((COORD_W+BAR_STEPS)'(q_hn_reg) >=
                            {q_item_reg.depth, BAR_STEPS'(0)});
            r_hrem_reg  <= COORD_W'(q_hn_reg >> BAR_STEPS);
            r_hlo_reg   <= q_hn_reg[BAR_W-1:0];

            for (int k = 0; k < BAR_STEPS; k++)
            begin
                s_item_reg[k]  <= (k == 0) ? r_item_reg  : s_item_reg[k-1];
                s_bzero_reg[k] <= (k == 0) ? r_bzero_reg : s_bzero_reg[k-1];
                s_bsat_reg[k]  <= (k == 0) ? r_bsat_reg  : s_bsat_reg[k-1];
                s_w16_reg[k]   <= (k == 0) ? r_w16_reg   : s_w16_reg[k-1];
                s_hsat_reg[k]  <= (k == 0) ? r_hsat_reg  : s_hsat_reg[k-1];
                s_brem_reg[k]  <= s_brem_next[k];
                s_blo_reg[k]   <= s_blo_next[k];
                s_bq_reg[k]    <= s_bq_next[k];
                s_hrem_reg[k]  <= s_hrem_next[k];
                s_hlo_reg[k]   <= s_hlo_next[k];
                s_hq_reg[k]    <= s_hq_next[k];
            end

            o_col_reg  <= s_last.col;
            o_draw_reg <= s_last.hit;
            o_blue_reg <= blue_next;
            o_bar_reg  <= bar_next;
        end
    end

    assign out_vld    = o_vld_reg;
    assign out_column = o_col_reg;
    assign draw       = o_draw_reg;
    assign blue_level = o_blue_reg;
    assign bar_height = o_bar_reg;

endmodule

`default_nettype wire

### hw/rtl/raycast_wall_column_shader_top.sv
// A column passes through the fisheye stages, then the shading stages, to out_valid.
// Throughput: one column per clock unless the output stalls; 15 cosine
// divider stages and 12 bar height divider stages set the depth.
// An output stall freezes every stage, so in_ready follows out_ready then.
// Reset clears all valid bits; fisheye_correct = 1, width 800, height 600.
`default_nettype none

module raycast_wall_column_shader_top import rcwcs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [CFG_W-1:0]   cfg_data,

    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [COL_W-1:0]   column,
    input  wire logic               hit,
    input  wire logic [COORD_W-1:0] hit_distance,
    input  wire logic [ANG_W-1:0]   view_angle,
    input  wire logic [ANG_W-1:0]   ray_angle,
    input  wire logic [COORD_W-1:0] origin_x,
    input  wire logic [COORD_W-1:0] origin_y,
    input  wire logic [COORD_W-1:0] wall_start_x,
    input  wire logic [COORD_W-1:0] wall_start_y,
    input  wire logic [COORD_W-1:0] wall_end_x,
    input  wire logic [COORD_W-1:0] wall_end_y,

    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [COL_W-1:0]        out_column,
    output logic                    draw,
    output logic [BLUE_W-1:0]       blue_level,
    output logic [BAR_W-1:0]        bar_height
);

    logic           fisheye_reg;
    logic [W_W-1:0] width_reg;
    logic [W_W-1:0] height_reg;

    logic           adv;
    item_t          in_item;
    logic           fe_vld;
    item_t          fe_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fisheye_reg <= 1'b1;
            width_reg   <= W_W'(800);
            height_reg  <= W_W'(600);
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FISHEYE: fisheye_reg <= cfg_data[0];
                REG_WIDTH:   width_reg   <= cfg_data[W_W-1:0];
                REG_HEIGHT:  height_reg  <= cfg_data[W_W-1:0];
                default:     ;
            endcase
        end
    end

    // whole pipeline moves unless a finished result is waiting for transfer
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    always_comb
    begin
        in_item.col    = column;
        in_item.hit    = hit;
        in_item.depth  = hit_distance;
        in_item.bright = 1'b0;
    end

    rcwcs_fisheye u_fisheye (
        .clk             (clk),
        .rst_n           (rst_n),
        .adv             (adv),
        .fisheye_correct (fisheye_reg),
        .in_vld          (in_valid),
        .in_item         (in_item),
        .view_angle      (view_angle),
        .ray_angle       (ray_angle),
        .origin_x        (origin_x),
        .origin_y        (origin_y),
        .wall_start_x    (wall_start_x),
        .wall_start_y    (wall_start_y),
        .wall_end_x      (wall_end_x),
        .wall_end_y      (wall_end_y),
        .out_vld         (fe_vld),
        .out_item        (fe_item)
    );

    rcwcs_shade u_shade (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .in_vld        (fe_vld),
        .in_item       (fe_item),
        .out_vld       (out_valid),
        .out_column    (out_column),
        .draw          (draw),
        .blue_level    (blue_level),
        .bar_height    (bar_height)
    );

endmodule

`default_nettype wire

### tb/tb_raycast_wall_column_shader_top.sv
`timescale 1ns / 100ps

import rcwcs_pkg::*;

typedef struct {
    logic [COL_W-1:0]   column;
    logic               hit;
    logic [COORD_W-1:0] hit_distance;
    logic [ANG_W-1:0]   view_angle;
    logic [ANG_W-1:0]   ray_angle;
    logic [COORD_W-1:0] origin_x;
    logic [COORD_W-1:0] origin_y;
    logic [COORD_W-1:0] wall_start_x;
    logic [COORD_W-1:0] wall_start_y;
    logic [COORD_W-1:0] wall_end_x;
    logic [COORD_W-1:0] wall_end_y;
} ray_hit_t;

typedef struct {
    logic [COL_W-1:0]  column;
    logic              draw;
    logic [BLUE_W-1:0] blue_level;
    logic [BAR_W-1:0]  bar_height;
} wall_column_t;

class column_scoreboard;
    localparam longint unsigned TURN      = 64'd1 << ANG_W;
    localparam longint unsigned COS_UNITY = 64'd1 << (2 * ANG_W);

    bit               fisheye;
    bit [W_W-1:0]     width;
    bit [W_W-1:0]     height;
    wall_column_t     expected_columns[$];
    int               errors;

    function new();
        fisheye = 1'b1;
        width   = 12'd800;
        height  = 12'd600;
        errors  = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        case (idx)
            REG_FISHEYE: fisheye = val[0];
            REG_WIDTH:   width   = val[W_W-1:0];
            REG_HEIGHT:  height  = val[W_W-1:0];
            default: ;
        endcase
    endfunction

    function wall_column_t shade_column(ray_hit_t rh);
        wall_column_t      res;
        logic [ANG_W-1:0]  diff;
        longint unsigned   d, a, cosq, depth, w, h, lit, fall, bar;
        bit                behind, bright;
        res.column     = rh.column;
        res.draw       = 1'b0;
        res.blue_level = '0;
        res.bar_height = '0;
        if (!rh.hit)
            return res;

        depth = rh.hit_distance;
        if (fisheye) begin
            // fold the wrapped difference into 0..quarter turn with a sign
            diff = rh.view_angle - rh.ray_angle;
            d = diff;
            if (d > TURN / 2)
                d = TURN - d;
            behind = d > TURN / 4;
            a = behind ? TURN / 2 - d : d;
            cosq = ((COS_UNITY - 16 * a * a) << COS_FRAC) / (COS_UNITY + 4 * a * a);
            depth = behind ? 0 : (depth * cosq) >> COS_FRAC;
        end

        bright = (rh.wall_start_y == rh.wall_end_y && rh.origin_y < rh.wall_start_y) ||
                 (rh.wall_start_x == rh.wall_end_x && rh.origin_x > rh.wall_start_x);
        w = (width == 0) ? 1 : width;
        h = height;
        lit  = 16 * w * (bright ? 255 : 140);
        fall = 150 * depth;
        if (lit <= fall)
            res.blue_level = '0;
        else if ((lit - fall) / (16 * w) > 255)
            res.blue_level = 8'd255;
        else
            res.blue_level = BLUE_W'((lit - fall) / (16 * w));

        if (depth == 0) begin
            bar = h;
        end
        else begin
            bar = (h * 800) / depth;
            if (bar > h)
                bar = h;
        end
        res.draw       = 1'b1;
        res.bar_height = BAR_W'(bar);
        return res;
    endfunction

    function void note_column(ray_hit_t rh);
        expected_columns = {expected_columns, shade_column(rh)};
    endfunction

    function void check_column(wall_column_t got);
        wall_column_t want;
        if (expected_columns.size() == 0) begin
            errors++;
            $display("%0t: unexpected column transfer col=%0d draw=%0d blue=%0d bar=%0d",
                     $time, got.column, got.draw, got.blue_level, got.bar_height);
            return;
        end
        want = expected_columns.pop_front();
        if (got.column !== want.column) begin
            errors++;
            $display("%0t: out_column expected %0d actual %0d", $time, want.column, got.column);
        end
        if (got.draw !== want.draw) begin
            errors++;
            $display("%0t: draw expected %0d actual %0d (col %0d)",
                     $time, want.draw, got.draw, want.column);
        end
        if (got.blue_level !== want.blue_level) begin
            errors++;
            $display("%0t: blue_level expected %0d actual %0d (col %0d)",
                     $time, want.blue_level, got.blue_level, want.column);
        end
        if (got.bar_height !== want.bar_height) begin
            errors++;
            $display("%0t: bar_height expected %0d actual %0d (col %0d)",
                     $time, want.bar_height, got.bar_height, want.column);
        end
    endfunction

    function int pending();
        return expected_columns.size();
    endfunction
endclass

module tb_raycast_wall_column_shader_top;

    localparam int HOLD_CYCLES  = 300;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 100;
    localparam int TAIL_CYCLES  = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [COL_W-1:0]   column = '0;
    logic               hit = 1'b0;
    logic [COORD_W-1:0] hit_distance = '0;
    logic [ANG_W-1:0]   view_angle = '0;
    logic [ANG_W-1:0]   ray_angle = '0;
    logic [COORD_W-1:0] origin_x = '0;
    logic [COORD_W-1:0] origin_y = '0;
    logic [COORD_W-1:0] wall_start_x = '0;
    logic [COORD_W-1:0] wall_start_y = '0;
    logic [COORD_W-1:0] wall_end_x = '0;
    logic [COORD_W-1:0] wall_end_y = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COL_W-1:0]   out_column;
    logic               draw;
    logic [BLUE_W-1:0]  blue_level;
    logic [BAR_W-1:0]   bar_height;

    column_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    raycast_wall_column_shader_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .column       (column),
        .hit          (hit),
        .hit_distance (hit_distance),
        .view_angle   (view_angle),
        .ray_angle    (ray_angle),
        .origin_x     (origin_x),
        .origin_y     (origin_y),
        .wall_start_x (wall_start_x),
        .wall_start_y (wall_start_y),
        .wall_end_x   (wall_end_x),
        .wall_end_y   (wall_end_y),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_column   (out_column),
        .draw         (draw),
        .blue_level   (blue_level),
        .bar_height   (bar_height)
    );

    always #4 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("raycast_wall_column_shader_top regression: fail");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // transfer monitor
    always @(posedge clk)
    begin
        ray_hit_t     rh;
        wall_column_t wc;
        if (rst_n) begin
            if (in_valid && in_ready) begin
                rh.column       = column;
                rh.hit          = hit;
                rh.hit_distance = hit_distance;
                rh.view_angle   = view_angle;
                rh.ray_angle    = ray_angle;
                rh.origin_x     = origin_x;
                rh.origin_y     = origin_y;
                rh.wall_start_x = wall_start_x;
                rh.wall_start_y = wall_start_y;
                rh.wall_end_x   = wall_end_x;
                rh.wall_end_y   = wall_end_y;
                sb.note_column(rh);
            end
            if (out_valid && out_ready) begin
                wc.column     = out_column;
                wc.draw       = draw;
                wc.blue_level = blue_level;
                wc.bar_height = bar_height;
                sb.check_column(wc);
            end
        end
    end

    function automatic ray_hit_t mk_hit(
        input logic [COL_W-1:0] col, input logic h, input logic [COORD_W-1:0] hd,
        input logic [ANG_W-1:0] va, input logic [ANG_W-1:0] ra,
        input logic [COORD_W-1:0] ox, input logic [COORD_W-1:0] oy,
        input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey);
        ray_hit_t rh;
        rh.column       = col;
        rh.hit          = h;
        rh.hit_distance = hd;
        rh.view_angle   = va;
        rh.ray_angle    = ra;
        rh.origin_x     = ox;
        rh.origin_y     = oy;
        rh.wall_start_x = sx;
        rh.wall_start_y = sy;
        rh.wall_end_x   = ex;
        rh.wall_end_y   = ey;
        return rh;
    endfunction

    function automatic ray_hit_t random_hit(input int w);
        ray_hit_t          rh;
        int                kind;
        int                span;
        logic [ANG_W-1:0]  off;
        rh.column       = COL_W'($urandom);
        rh.hit          = ($urandom_range(9) != 0);
        rh.view_angle   = ANG_W'($urandom);
        rh.origin_x     = COORD_W'($urandom);
        rh.origin_y     = COORD_W'($urandom);
        rh.wall_start_x = COORD_W'($urandom);
        rh.wall_start_y = COORD_W'($urandom);
        rh.wall_end_x   = COORD_W'($urandom);
        rh.wall_end_y   = COORD_W'($urandom);

        // mostly rays within the field of view, some from anywhere
        if ($urandom_range(9) < 7) begin
            off = ANG_W'($urandom_range(700));
            rh.ray_angle = $urandom_range(1) ? rh.view_angle + off : rh.view_angle - off;
        end
        else begin
            rh.ray_angle = ANG_W'($urandom);
        end

        // distance over the full range, short, or near the brightness falloff and the bar cap
        span = (w == 0 ? 1 : w) * 32;
        if (span > 65535)
            span = 65535;
        case ($urandom_range(3))
            0: rh.hit_distance = COORD_W'($urandom);
            1: rh.hit_distance = COORD_W'($urandom_range(255));
            2: rh.hit_distance = COORD_W'($urandom_range(span));
            default: rh.hit_distance = COORD_W'($urandom_range(4000));
        endcase

        kind = $urandom_range(9);
        if (kind <= 3 || kind == 8)
            rh.wall_end_y = rh.wall_start_y;
        if ((kind >= 4 && kind <= 7) || kind == 8)
            rh.wall_end_x = rh.wall_start_x;
        if ($urandom_range(3) == 0)
            rh.origin_y = rh.wall_start_y;
        if ($urandom_range(3) == 0)
            rh.origin_x = rh.wall_start_x;
        return rh;
    endfunction

    task automatic put_column(input ray_hit_t rh);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        column       <= rh.column;
        hit          <= rh.hit;
        hit_distance <= rh.hit_distance;
        view_angle   <= rh.view_angle;
        ray_angle    <= rh.ray_angle;
        origin_x     <= rh.origin_x;
        origin_y     <= rh.origin_y;
        wall_start_x <= rh.wall_start_x;
        wall_start_y <= rh.wall_start_y;
        wall_end_x   <= rh.wall_end_x;
        wall_end_y   <= rh.wall_end_y;
        in_valid     <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_screen(input logic fe, input int w, input int h);
        write_reg(REG_FISHEYE, CFG_W'(fe));
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
    endtask

    task automatic run_directed();
        // no hit, both column extremes
        put_column(mk_hit(8'd255, 1'b0, '1, '1, '0, '1, '1, '1, '1, '1, '1));
        put_column(mk_hit(8'd0, 1'b0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        // zero and maximum distance, straight ahead
        put_column(mk_hit(8'd1, 1'b1, 16'd0, 12'd0, 12'd0, 16'd5, 16'd5, 16'd1, 16'd9,
                          16'd7, 16'd9));
        put_column(mk_hit(8'd2, 1'b1, 16'hFFFF, 12'hFFF, 12'hFFF, '0, '0, '1, '1, '0, '1));
        // ray pointing backward: corrected distance saturates to zero
        put_column(mk_hit(8'd3, 1'b1, 16'd3000, 12'd0, 12'd2048, 16'd0, 16'd0, 16'd1, 16'd2,
                          16'd3, 16'd4));
        put_column(mk_hit(8'd4, 1'b1, 16'd3000, 12'd2047, 12'd1022, 16'd0, 16'd0, 16'd1,
                          16'd2, 16'd3, 16'd4));
        // exactly a quarter turn, both ways around, then one step off straight ahead
        put_column(mk_hit(8'd5, 1'b1, 16'd3000, 12'd1024, 12'd0, 16'd0, 16'd0, 16'd1, 16'd2,
                          16'd3, 16'd4));
        put_column(mk_hit(8'd6, 1'b1, 16'd3000, 12'd0, 12'd1024, 16'd0, 16'd0, 16'd1, 16'd2,
                          16'd3, 16'd4));
        put_column(mk_hit(8'd7, 1'b1, 16'd3000, 12'd0, 12'd1, 16'd0, 16'd0, 16'd1, 16'd2,
                          16'd3, 16'd4));
        // horizontal wall: origin above brightens, level does not
        put_column(mk_hit(8'd8, 1'b1, 16'd1600, 12'd100, 12'd90, 16'd50, 16'd99, 16'd10,
                          16'd100, 16'd200, 16'd100));
        put_column(mk_hit(8'd9, 1'b1, 16'd1600, 12'd100, 12'd90, 16'd50, 16'd100, 16'd10,
                          16'd100, 16'd200, 16'd100));
        // vertical wall: origin to the right brightens, level does not
        put_column(mk_hit(8'd10, 1'b1, 16'd1600, 12'd4000, 12'd10, 16'd301, 16'd5, 16'd300,
                          16'd0, 16'd300, 16'd900));
        put_column(mk_hit(8'd11, 1'b1, 16'd1600, 12'd4000, 12'd10, 16'd300, 16'd5, 16'd300,
                          16'd0, 16'd300, 16'd900));
        // point wall, one test true, then neither
        put_column(mk_hit(8'd12, 1'b1, 16'd500, 12'd7, 12'd7, 16'd100, 16'd200, 16'd50,
                          16'd50, 16'd50, 16'd50));
        put_column(mk_hit(8'd13, 1'b1, 16'd500, 12'd7, 12'd7, 16'd10, 16'd200, 16'd50,
                          16'd50, 16'd50, 16'd50));
        // brightness reaching zero right at the falloff distance
        put_column(mk_hit(8'd14, 1'b1, 16'd21760, 12'd0, 12'd0, 16'd0, 16'd0, 16'd1, 16'd9,
                          16'd2, 16'd9));
        put_column(mk_hit(8'd15, 1'b1, 16'd21759, 12'd0, 12'd0, 16'd0, 16'd0, 16'd1, 16'd9,
                          16'd2, 16'd9));
        // bar height at and around the cap
        put_column(mk_hit(8'd16, 1'b1, 16'd800, 12'd0, 12'd0, 16'd0, 16'd0, 16'd1, 16'd2,
                          16'd3, 16'd4));
        put_column(mk_hit(8'd17, 1'b1, 16'd801, 12'd0, 12'd0, 16'd0, 16'd0, 16'd1, 16'd2,
                          16'd3, 16'd4));
        put_column(mk_hit(8'd18, 1'b1, 16'd1, 12'd0, 12'd0, 16'd0, 16'd0, 16'd1, 16'd2,
                          16'd3, 16'd4));
        put_column(mk_hit(8'd128, 1'b1, '1, '0, '1, '1, '1, '1, '1, '1, '1));
    endtask

    initial
    begin
        int w;
        int h;
        logic fe;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();

        for (int p = 0; p < PHASES; p++) begin
            drain();
            fe = 1'b1;
            w  = $urandom_range(1, 4095);
            h  = $urandom_range(1, 4095);
            case (p)
                0: begin w = 800;  h = 600;  end
                1: begin fe = 1'b0; w = 4095; h = 4095; end
                2: begin w = 1;    h = 1;    end
                4: begin fe = 1'b0; w = 0; h = 0; end  // degenerate screen
                6: begin fe = 1'($urandom_range(1)); w = $urandom_range(1, 200); end
                7: begin w = 320;  h = 200;  end
                default: ;
            endcase
            set_screen(fe, w, h);

            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 55; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 55; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // long output hold-off while input keeps coming: pipeline fills up
                if (p == 5 && i == 10)
                    hold_req++;
                // sender pause until the pipeline is empty
                if (p == 7 && i == PHASE_ITEMS / 2)
                    drain();
                put_column(random_hit(w));
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("raycast_wall_column_shader_top regression: pass");
        else
            $display("raycast_wall_column_shader_top regression: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/rcwcs_pkg.sv
hw/rtl/rcwcs_fisheye.sv
hw/rtl/rcwcs_shade.sv
hw/rtl/raycast_wall_column_shader_top.sv
tb/tb_raycast_wall_column_shader_top.sv
